[rtl/ecms_pkg.sv]
// ----------------------------------------------------------------------------
// ecms_pkg
// Shared types and constants for the EMA crossover momentum signal block.
// ----------------------------------------------------------------------------
package ecms_pkg;

    localparam int AVG_W   = 48;
    localparam int PRICE_W = 32;
    localparam int FRAC_W  = 16;
    localparam int ALPHA_W = 16;
    localparam int LIMIT_W = 24;
    localparam int QTY_W   = 32;
    localparam int TICK_W  = 7;
    localparam int SYM_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_QUANTITY = 2'd3;

    // Configuration reset values
    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST     = 16'd10082;
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST     = 16'd4855;
    localparam logic [LIMIT_W-1:0] MOMENTUM_LIMIT_RST = 24'd16777;
    localparam logic [QTY_W-1:0]   ORDER_QUANTITY_RST = 32'd1;

    // Action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_ENTER = 2'd1;
    localparam logic [1:0] ACT_EXIT  = 2'd2;

    // Order sides
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // One table entry per symbol
    typedef struct packed {
        logic [AVG_W-1:0]  fast_avg;
        logic [AVG_W-1:0]  slow_avg;
        logic              started;
        logic [TICK_W-1:0] ticks;
        logic              holding;
        logic              held_side;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_CMP  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

endpackage

[rtl/ecms_ram.sv]
// ----------------------------------------------------------------------------
// ecms_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ecms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ema_crossover_momentum_signal_top.sv]
// ----------------------------------------------------------------------------
// ema_crossover_momentum_signal_top
// Per-symbol fast/slow EMA crossover with relative momentum entry and exit.
// ----------------------------------------------------------------------------
// Each tick goes through these steps in order: accept and table read, average
// difference, alpha multiply and update, limit-times-slow multiply, then
// compare, table write-back and result load. The per-symbol table memory holds
// one tick in flight at a time. A finished result sits in the output register
// while the next tick is taken; the last step waits only if that register is
// still full and stalled. After reset the table is cleared one entry a cycle,
// with in_stall high; configuration writes are taken at any time. Ticks for a
// symbol index at or above NUM_SYMBOLS return action 0 and leave the table
// untouched.
// ----------------------------------------------------------------------------
module ema_crossover_momentum_signal_top #(
    parameter int NUM_SYMBOLS  = 16,
    parameter int HISTORY_CAP  = 100,
    parameter int WARMUP_TICKS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                wr_en,
    input  logic [ecms_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [ecms_pkg::CFG_DATA_W-1:0]     wr_data,
    // tick channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ecms_pkg::SYM_W-1:0]          symbol_index,
    input  logic [ecms_pkg::PRICE_W-1:0]        tick_price,
    // order channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          action,
    output logic                                order_side,
    output logic [ecms_pkg::PRICE_W-1:0]        order_price,
    output logic [ecms_pkg::QTY_W-1:0]          order_size
);

    localparam int AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int SW      = AW + ecms_pkg::SYM_W;
    localparam int AVG_W   = ecms_pkg::AVG_W;
    localparam int PROD_W  = AVG_W + ecms_pkg::ALPHA_W;
    localparam int RHS_W   = AVG_W + ecms_pkg::LIMIT_W;
    localparam int CMP_W   = AVG_W + 25;
    localparam int TICK_W  = ecms_pkg::TICK_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ecms_pkg::ALPHA_W-1:0] fast_alpha_reg;
    logic [ecms_pkg::ALPHA_W-1:0] slow_alpha_reg;
    logic [ecms_pkg::LIMIT_W-1:0] momentum_limit_reg;
    logic [ecms_pkg::QTY_W-1:0]   order_quantity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_alpha_reg     <= ecms_pkg::FAST_ALPHA_RST;
            slow_alpha_reg     <= ecms_pkg::SLOW_ALPHA_RST;
            momentum_limit_reg <= ecms_pkg::MOMENTUM_LIMIT_RST;
            order_quantity_reg <= ecms_pkg::ORDER_QUANTITY_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ecms_pkg::REG_FAST_ALPHA:     fast_alpha_reg     <= wr_data[15:0];
                ecms_pkg::REG_SLOW_ALPHA:     slow_alpha_reg     <= wr_data[15:0];
                ecms_pkg::REG_MOMENTUM_LIMIT: momentum_limit_reg <= wr_data[23:0];
                ecms_pkg::REG_ORDER_QUANTITY: order_quantity_reg <= wr_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    ecms_pkg::state_t state_reg, state_next;
    logic             clearing_reg;
    logic [AW-1:0]    clr_idx_reg;
    logic             out_valid_reg;

    logic accept;
    logic out_take;
    logic done_fire;

    assign in_stall  = clearing_reg || (state_reg != ecms_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign done_fire = (state_reg == ecms_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecms_pkg::S_IDLE: if (accept) state_next = ecms_pkg::S_READ;
            ecms_pkg::S_READ: state_next = ecms_pkg::S_MUL;
            ecms_pkg::S_MUL:  state_next = ecms_pkg::S_CMP;
            ecms_pkg::S_CMP:  state_next = ecms_pkg::S_DONE;
            ecms_pkg::S_DONE: if (done_fire) state_next = ecms_pkg::S_IDLE;
            default:          state_next = ecms_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecms_pkg::S_IDLE;
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing_reg)
            begin
                if (clr_idx_reg == AW'(NUM_SYMBOLS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Symbol table
    // ------------------------------------------------------------------
    logic [SW-1:0]                 sym_wide;
    logic [AW-1:0]                 rd_addr;
    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    ecms_pkg::entry_t              ram_wr_data;
    logic [ecms_pkg::ENTRY_W-1:0]  ram_rd_data;
    ecms_pkg::entry_t              ent_rd;

    assign sym_wide = {AW'(0), symbol_index};
    assign rd_addr  = sym_wide[AW-1:0];
    assign ent_rd   = ecms_pkg::entry_t'(ram_rd_data);

    ecms_ram #(
        .WIDTH (ecms_pkg::ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [AW-1:0]                  addr_reg;
    logic                           in_range_reg;
    logic [ecms_pkg::PRICE_W-1:0]   price_reg;
    ecms_pkg::entry_t               ent_reg;
    logic [AVG_W-1:0]               fd_reg, sd_reg;
    logic                           fge_reg, sge_reg;
    logic [AVG_W-1:0]               f_reg, s_reg;
    logic [TICK_W-1:0]              ticks_reg;
    logic [AVG_W-1:0]               mag_reg;
    logic                           up_reg, down_reg;
    logic [RHS_W-1:0]               rhs_reg;

    logic [1:0]                     action_reg;
    logic                           side_reg;
    logic [ecms_pkg::PRICE_W-1:0]   order_price_reg;
    logic [ecms_pkg::QTY_W-1:0]     order_size_reg;

    logic [AVG_W-1:0]  p48;
    logic [AVG_W-1:0]  fd_next, sd_next;
    logic [PROD_W-1:0] fprod, sprod;
    logic [AVG_W-1:0]  fstep, sstep;
    logic [AVG_W-1:0]  f_next, s_next;
    logic [TICK_W-1:0] ticks_next;
    logic [AVG_W-1:0]  mag_next;
    logic [CMP_W-1:0]  lhs_enter, lhs_exit, rhs_cmp;
    logic              enter_hit, exit_hit, against;
    logic [1:0]        action_next;
    logic              side_next;
    ecms_pkg::entry_t  ent_new;

    assign p48 = {price_reg, {ecms_pkg::FRAC_W{1'b0}}};

    // distance from each average to the price
    assign fd_next = (p48 >= ent_rd.fast_avg) ? (p48 - ent_rd.fast_avg)
                                              : (ent_rd.fast_avg - p48);
    assign sd_next = (p48 >= ent_rd.slow_avg) ? (p48 - ent_rd.slow_avg)
                                              : (ent_rd.slow_avg - p48);

    // step is truncated toward the old average
    assign fprod = fd_reg * fast_alpha_reg;
    assign sprod = sd_reg * slow_alpha_reg;
    assign fstep = fprod[PROD_W-1:ecms_pkg::FRAC_W];
    assign sstep = sprod[PROD_W-1:ecms_pkg::FRAC_W];

    always_comb
    begin
        if (!ent_reg.started)
        begin
            f_next = p48;
            s_next = p48;
        end
        else
        begin
            f_next = fge_reg ? (ent_reg.fast_avg + fstep) : (ent_reg.fast_avg - fstep);
            s_next = sge_reg ? (ent_reg.slow_avg + sstep) : (ent_reg.slow_avg - sstep);
        end
        if (ent_reg.ticks < TICK_W'(HISTORY_CAP))
        begin
            ticks_next = ent_reg.ticks + 1'b1;
        end
        else
        begin
            ticks_next = ent_reg.ticks;
        end
    end

    assign mag_next = (f_reg > s_reg) ? (f_reg - s_reg) : (s_reg - f_reg);

    // exact compare of mag * 2^k against limit * slow
    assign lhs_enter = {1'b0, mag_reg, 24'd0};
    assign lhs_exit  = {mag_reg, 25'd0};
    assign rhs_cmp   = {1'b0, rhs_reg};
    assign enter_hit = lhs_enter > rhs_cmp;
    assign exit_hit  = lhs_exit > rhs_cmp;
    assign against   = (ent_reg.held_side == ecms_pkg::SIDE_BUY) ? down_reg : up_reg;

    always_comb
    begin
        action_next = ecms_pkg::ACT_NONE;
        side_next   = ecms_pkg::SIDE_BUY;
        ent_new.fast_avg  = f_reg;
        ent_new.slow_avg  = s_reg;
        ent_new.started   = 1'b1;
        ent_new.ticks     = ticks_reg;
        ent_new.holding   = ent_reg.holding;
        ent_new.held_side = ent_reg.held_side;
        if (!ent_reg.holding)
        begin
            if ((ticks_reg >= TICK_W'(WARMUP_TICKS)) && enter_hit)
            begin
                action_next       = ecms_pkg::ACT_ENTER;
                side_next         = up_reg ? ecms_pkg::SIDE_BUY : ecms_pkg::SIDE_SELL;
                ent_new.holding   = 1'b1;
                ent_new.held_side = side_next;
            end
        end
        else if (against && exit_hit)
        begin
            action_next     = ecms_pkg::ACT_EXIT;
            side_next       = ~ent_reg.held_side;
            ent_new.holding = 1'b0;
        end
    end

    // write port: clearing pass, else write-back of the finished tick
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = done_fire && in_range_reg;
            ram_wr_addr = addr_reg;
            ram_wr_data = ent_new;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ecms_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    addr_reg     <= rd_addr;
                    in_range_reg <= (sym_wide < SW'(NUM_SYMBOLS));
                    price_reg    <= tick_price;
                end
            end
            ecms_pkg::S_READ:
            begin
                ent_reg <= ent_rd;
                fd_reg  <= fd_next;
                sd_reg  <= sd_next;
                fge_reg <= (p48 >= ent_rd.fast_avg);
                sge_reg <= (p48 >= ent_rd.slow_avg);
            end
            ecms_pkg::S_MUL:
            begin
                f_reg     <= f_next;
                s_reg     <= s_next;
                ticks_reg <= ticks_next;
            end
            ecms_pkg::S_CMP:
            begin
                mag_reg  <= mag_next;
                up_reg   <= (f_reg > s_reg);
                down_reg <= (f_reg < s_reg);
                rhs_reg  <= momentum_limit_reg * s_reg;
            end
            ecms_pkg::S_DONE:
            begin
                if (done_fire)
                begin
                    if (in_range_reg && (action_next != ecms_pkg::ACT_NONE))
                    begin
                        action_reg      <= action_next;
                        side_reg        <= side_next;
                        order_price_reg <= price_reg;
                        order_size_reg  <= order_quantity_reg;
                    end
                    else
                    begin
                        action_reg      <= ecms_pkg::ACT_NONE;
                        side_reg        <= ecms_pkg::SIDE_BUY;
                        order_price_reg <= '0;
                        order_size_reg  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign order_side  = side_reg;
    assign order_price = order_price_reg;
    assign order_size  = order_size_reg;

endmodule
